### design/cbss_pkg.sv
// Shared constants and divider handshake types for the code block segmentation sizer.
package cbss_pkg;

  localparam int SIZE_WIDTH  = 16;
  localparam int LIMIT_W     = 16;
  localparam int CODED_W     = 18;
  localparam int BLOCKS_W    = 11;
  localparam int FILLER_W    = 10;
  localparam int CFG_INDEX_W = 8;

  localparam int DIVQ_W   = SIZE_WIDTH;
  localparam int DIVR_W   = CODED_W;
  localparam int DIVCNT_W = $clog2(DIVQ_W + 1);

  localparam logic [LIMIT_W-1:0] MIN_LIMIT       = LIMIT_W'(64);
  localparam logic [LIMIT_W-1:0] CONV_LIMIT_RST  = LIMIT_W'(504);
  localparam logic [LIMIT_W-1:0] TURBO_LIMIT_RST = LIMIT_W'(5114);
  localparam logic [CODED_W-1:0] CONV_TAIL       = CODED_W'(16);
  localparam logic [CODED_W-1:0] TURBO_TAIL      = CODED_W'(12);

  // x / 3 == (x * RECIP3) >> 17, exact for every 16-bit x
  localparam logic [15:0] RECIP3 = 16'hAAAB;

  localparam logic [CFG_INDEX_W-1:0] REG_CONV_LIMIT  = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_TURBO_LIMIT = CFG_INDEX_W'(1);

  typedef struct packed {
    logic              start;
    logic [DIVQ_W-1:0] dividend;
    logic [DIVR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [DIVQ_W-1:0] quot;
    logic [DIVR_W-1:0] rem;
  } div_rsp_t;

endpackage

### design/cbss_div.sv
// Restoring divider, one quotient bit per cycle.
module cbss_div
  import cbss_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic                busy;
  logic                done;
  logic [DIVCNT_W-1:0] cnt;
  logic [DIVQ_W-1:0]   quo;
  logic [DIVR_W-1:0]   rem;
  logic [DIVR_W-1:0]   dvsr;
  logic [DIVR_W:0]     trial;
  logic [DIVR_W:0]     diff;
  logic                fits;

  assign trial = {rem, quo[DIVQ_W-1]};
  assign fits  = trial >= {1'b0, dvsr};
  assign diff  = trial - {1'b0, dvsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + DIVCNT_W'(1);
        if (cnt == DIVCNT_W'(DIVQ_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk) begin
    if (req.start) begin
      quo  <= req.dividend;
      rem  <= '0;
      dvsr <= req.divisor;
    end else if (busy) begin
      quo <= {quo[DIVQ_W-2:0], fits};
      rem <= fits ? diff[DIVR_W-1:0] : trial[DIVR_W-1:0];
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.quot = quo;
  assign rsp.rem  = rem;

endmodule

### design/code_block_segmentation_sizer.sv
// Top level: UMTS code block segmentation sizer with iterative divider sequencer.
// Encode: two divisions (k / Z, then k / blocks) after acceptance; a zero input skips both.
// Decode: one division and the estimate, then each pass of the fit search repeats the encode
// divisions and products, then the result register; no fit at the estimate skips the search.
// One transaction in flight; s_tready rises in the same cycle as the registered result's m_tvalid.
// Sync active-high rst: idle, no result pending, limits back to 504 / 5114.
module code_block_segmentation_sizer
  import cbss_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  // config write channel
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [LIMIT_W-1:0]     cfg_data,
  // input stream
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [15:0]            s_tdata,   // size_bits[15:0]
  input  logic [1:0]             s_tuser,   // func[0], use_turbo[1]
  // result stream
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [71:0]            m_tdata,   // info_bits[15:0], coded_bits[33:16],
                                            // block_count[44:34], block_size[60:45],
                                            // filler_bits[70:61], zero pad[71]
  output logic                   m_tuser    // no_fit
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DEC_C,     // start size / zout
    ST_DEC_EST,   // first guess of info count
    ST_SEG_START, // start k / Z
    ST_SEG_KS,    // latch blocks, start k / blocks
    ST_SEG_KDONE, // latch block size
    ST_SEG_PROD,  // filler and coded size
    ST_SEG_CHECK, // fit test, decrement in decode
    ST_DIV_WAIT,
    ST_OUT
  } state_t;

  state_t state;
  state_t ret;

  // config registers
  logic [LIMIT_W-1:0] conv_limit;
  logic [LIMIT_W-1:0] turbo_limit;

  // item context
  logic                  func_q;
  logic                  turbo_q;
  logic [SIZE_WIDTH-1:0] size_q;
  logic [LIMIT_W-1:0]    zeff;

  // working segmentation
  logic [SIZE_WIDTH-1:0] k;
  logic [BLOCKS_W-1:0]   blocks;
  logic [SIZE_WIDTH-1:0] ks;
  logic [FILLER_W-1:0]   fill;
  logic [CODED_W-1:0]    coded;
  logic                  nofit;

  div_req_t div_req;
  div_rsp_t div_rsp;

  cbss_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // ---------------------------------------------------------------
  // Combinational helpers
  // ---------------------------------------------------------------
  logic [LIMIT_W-1:0]            lim_sel;
  logic [LIMIT_W-1:0]            zeff_in;
  logic [CODED_W-1:0]            zout;
  logic [SIZE_WIDTH-1:0]         q_ceil;
  logic [SIZE_WIDTH-1:0]         ctail;
  logic                          est_ok;
  logic [SIZE_WIDTH-1:0]         est_diff;
  logic [31:0]                   div3_prod;
  logic [CODED_W-1:0]            rate_k;
  logic [BLOCKS_W+SIZE_WIDTH-1:0] prod_fill;
  logic [BLOCKS_W+CODED_W-1:0]   prod_coded;
  logic [BLOCKS_W+SIZE_WIDTH-1:0] fill_full;

  assign lim_sel = s_tuser[1] ? turbo_limit : conv_limit;
  assign zeff_in = (lim_sel < MIN_LIMIT) ? MIN_LIMIT : lim_sel;

  // coded size of one full block: 3Z+12 or 2Z+16
  assign zout = turbo_q ? (CODED_W'(zeff) + (CODED_W'(zeff) << 1) + TURBO_TAIL)
                        : ((CODED_W'(zeff) << 1) + CONV_TAIL);

  // ceiling of the last quotient
  assign q_ceil = div_rsp.quot + SIZE_WIDTH'(div_rsp.rem != '0);

  // tail bits for c blocks: 12c or 16c (c is small, never overflows)
  assign ctail    = turbo_q ? ((q_ceil << 3) + (q_ceil << 2)) : (q_ceil << 4);
  assign est_ok   = size_q >= ctail;
  assign est_diff = size_q - ctail;

  // turbo estimate: est_diff / 3 by reciprocal multiply, quotient in bits [31:17]
  assign div3_prod = 32'(est_diff) * 32'(RECIP3);

  assign rate_k     = turbo_q ? (CODED_W'(ks) + (CODED_W'(ks) << 1) + TURBO_TAIL)
                              : ((CODED_W'(ks) << 1) + CONV_TAIL);
  assign prod_fill  = blocks * ks;
  assign prod_coded = blocks * rate_k;
  assign fill_full  = prod_fill - (BLOCKS_W+SIZE_WIDTH)'(k);

  // divider requests by state
  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = k;
    div_req.divisor  = DIVR_W'(zeff);
    unique case (state)
      ST_DEC_C: begin
        div_req.start    = 1'b1;
        div_req.dividend = size_q;
        div_req.divisor  = zout;
      end
      ST_SEG_START: begin
        div_req.start    = (k != '0);
      end
      ST_SEG_KS: begin
        div_req.start    = 1'b1;
        div_req.divisor  = DIVR_W'(q_ceil);
      end
      default: begin
        div_req.start    = 1'b0;
      end
    endcase
  end

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == ST_IDLE);

  // ---------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      ret         <= ST_IDLE;
      m_tvalid    <= 1'b0;
      conv_limit  <= CONV_LIMIT_RST;
      turbo_limit <= TURBO_LIMIT_RST;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_CONV_LIMIT:  conv_limit  <= cfg_data;
          REG_TURBO_LIMIT: turbo_limit <= cfg_data;
          default: ;
        endcase
      end

      // in ST_OUT the result register is reloaded below
      if (m_tvalid && m_tready && (state != ST_OUT)) m_tvalid <= 1'b0;

      unique case (state)
        ST_IDLE: begin
          if (s_tvalid && s_tready) begin
            func_q  <= s_tuser[0];
            turbo_q <= s_tuser[1];
            size_q  <= s_tdata[SIZE_WIDTH-1:0];
            zeff    <= zeff_in;
            k       <= s_tdata[SIZE_WIDTH-1:0];
            state   <= s_tuser[0] ? ST_DEC_C : ST_SEG_START;
          end
        end
        ST_DEC_C: begin
          ret   <= ST_DEC_EST;
          state <= ST_DIV_WAIT;
        end
        ST_DEC_EST: begin
          if (!est_ok) begin
            k     <= '0;
          end else if (turbo_q) begin
            k     <= SIZE_WIDTH'(div3_prod[31:17]);
          end else begin
            k     <= est_diff >> 1;
          end
          state <= ST_SEG_START;
        end
        ST_SEG_START: begin
          if (k == '0) begin
            // nothing to segment; in decode this means no fit
            blocks <= '0;
            ks     <= '0;
            fill   <= '0;
            coded  <= '0;
            nofit  <= func_q;
            state  <= ST_OUT;
          end else begin
            nofit <= 1'b0;
            ret   <= ST_SEG_KS;
            state <= ST_DIV_WAIT;
          end
        end
        ST_SEG_KS: begin
          blocks <= q_ceil[BLOCKS_W-1:0];
          ret    <= ST_SEG_KDONE;
          state  <= ST_DIV_WAIT;
        end
        ST_SEG_KDONE: begin
          ks    <= q_ceil;
          state <= ST_SEG_PROD;
        end
        ST_SEG_PROD: begin
          fill  <= fill_full[FILLER_W-1:0];
          coded <= prod_coded[CODED_W-1:0];
          state <= ST_SEG_CHECK;
        end
        ST_SEG_CHECK: begin
          if (func_q && (coded > CODED_W'(size_q))) begin
            k     <= k - SIZE_WIDTH'(1);
            state <= ST_SEG_START;
          end else begin
            state <= ST_OUT;
          end
        end
        ST_DIV_WAIT: begin
          if (div_rsp.done) state <= ret;
        end
        ST_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {1'b0, fill, ks, blocks, coded, k};
            m_tuser  <= nofit;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // ---------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------
  a_nofit_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == '0)
    else $error("no_fit result with nonzero counts");

  a_fill_lt_blocks: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[44:34] != '0) |-> m_tdata[70:61] < m_tdata[44:34])
    else $error("filler not below block count");

  a_div_free: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  a_div_wait_done: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV_WAIT) && !div_rsp.busy |-> div_rsp.done)
    else $error("waiting on an idle divider");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> state != ST_IDLE)
    else $error("accepted transaction not started");

endmodule
